FILE: rtl/gcs_pkg.sv
`timescale 1ns / 1ps
package gcs_pkg;

    // CORDIC depth and table length
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int STEP_W       = 5;
    localparam int NLANE        = 5;

    // Datapath widths
    localparam int XW      = 20;   // CORDIC x and y
    localparam int AW      = 26;   // CORDIC angle, 2^-16 degree
    localparam int RW      = 27;   // raw angle before reduction
    localparam int TW      = 18;   // Q16 sine and cosine
    localparam int HW      = 17;   // haversine term, [0, 1.0] in Q16
    localparam int SQ_W    = 33;   // square root operand
    localparam int SQ_N    = 17;   // square root steps
    localparam int RAD_W   = 13;
    localparam int HOUR_W  = 10;
    localparam int K_W     = 31;
    localparam int ZC_W    = 23;
    localparam int NUM_W   = 55;
    localparam int B_W     = 25;
    localparam int DIVN_W  = 15;
    localparam int DIV_N   = DIVN_W;
    localparam int DIV_IW  = 4;
    localparam int SPD_W   = 14;
    localparam int CP_W    = 4;

    // Angles in 2^-16 degree
    localparam int ANG_FULL       = 23592960;
    localparam int ANG_HALF       = 11796480;
    localparam int ANG_QUARTER    = 5898240;
    localparam int ONE_Q16        = 65536;
    localparam int CORDIC_GAIN    = 39797;
    localparam int NM_PER_DEG_Q24 = 254451;
    localparam int COMPASS_OFFSET = 737280;
    localparam int RECIP_45_Q16   = 1457;
    localparam int SPEED_MAX      = 16383;
    localparam int RADIUS_RESET   = 3959;
    localparam int K_RESET        = RADIUS_RESET * NM_PER_DEG_Q24;

    // Register map (index taken from paddr[2])
    localparam logic [0:0] REG_RADIUS = 1'b0;

    // Pipeline positions
    localparam int ST_P1   = CORDIC_STEPS + 1;
    localparam int ST_P2   = CORDIC_STEPS + 2;
    localparam int ST_P3   = CORDIC_STEPS + 3;
    localparam int ST_SQ0  = CORDIC_STEPS + 4;
    localparam int ST_VC0  = ST_SQ0 + SQ_N;
    localparam int ST_Q1   = ST_VC0 + CORDIC_STEPS;
    localparam int ST_Q2   = ST_Q1 + 1;
    localparam int ST_DV0  = ST_Q2 + 1;
    localparam int ST_OUT  = ST_DV0 + DIV_N;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] z;
        logic [1:0]           tag;
    } cord_t;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sq_t;

    typedef struct packed {
        logic [DIVN_W-1:0] n;
        logic [HOUR_W-1:0] rem;
        logic [DIVN_W-1:0] q;
    } div_t;

    typedef struct packed {
        logic              vld;
        logic              ok;
        logic [HOUR_W-1:0] hours;
    } side_t;

    function automatic logic signed [AW-1:0] gcs_atan(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    return 26'sd2949120;
            5'd1:    return 26'sd1740967;
            5'd2:    return 26'sd919879;
            5'd3:    return 26'sd466945;
            5'd4:    return 26'sd234379;
            5'd5:    return 26'sd117302;
            5'd6:    return 26'sd58666;
            5'd7:    return 26'sd29335;
            5'd8:    return 26'sd14668;
            5'd9:    return 26'sd7334;
            5'd10:   return 26'sd3667;
            5'd11:   return 26'sd1833;
            5'd12:   return 26'sd917;
            5'd13:   return 26'sd458;
            5'd14:   return 26'sd229;
            5'd15:   return 26'sd115;
            5'd16:   return 26'sd57;
            5'd17:   return 26'sd29;
            5'd18:   return 26'sd14;
            5'd19:   return 26'sd7;
            5'd20:   return 26'sd4;
            5'd21:   return 26'sd2;
            5'd22:   return 26'sd1;
            default: return 26'sd0;
        endcase
    endfunction

    // Wrap into [-180, 180), fold into [-90, 90], seed the rotation
    function automatic cord_t gcs_rot_init(input logic signed [RW-1:0] a);
        logic signed [RW-1:0] r;
        cord_t c;
        r = a;
        c.tag = '0;
        if (r >= RW'(ANG_HALF))
            r = r - RW'(ANG_FULL);
        else if (r < -RW'(ANG_HALF))
            r = r + RW'(ANG_FULL);
        if (r > RW'(ANG_QUARTER))
        begin
            r = RW'(ANG_HALF) - r;
            c.tag[0] = 1'b1;
        end
        else if (r < -RW'(ANG_QUARTER))
        begin
            r = -RW'(ANG_HALF) - r;
            c.tag[0] = 1'b1;
        end
        c.x = XW'(CORDIC_GAIN);
        c.y = '0;
        c.z = AW'(r);
        return c;
    endfunction

    function automatic logic signed [TW-1:0] gcs_clamp(input logic signed [XW-1:0] v);
        if (v > XW'(ONE_Q16))
            return TW'(ONE_Q16);
        else if (v < -XW'(ONE_Q16))
            return -TW'(ONE_Q16);
        else
            return TW'(v);
    endfunction

    function automatic logic signed [TW-1:0] gcs_sin(input cord_t c);
        return gcs_clamp(c.y);
    endfunction

    function automatic logic signed [TW-1:0] gcs_cos(input cord_t c);
        return gcs_clamp(c.tag[0] ? -c.x : c.x);
    endfunction

    function automatic logic signed [TW-1:0] gcs_mulq(input logic signed [TW-1:0] a,
                                                      input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b;
        return TW'(p >>> 16);
    endfunction

endpackage

FILE: rtl/gcs_rot_cell.sv
`timescale 1ns / 1ps
module gcs_rot_cell (
    input  logic                       clk,
    input  logic [gcs_pkg::STEP_W-1:0] step,
    input  gcs_pkg::cord_t             din,
    output gcs_pkg::cord_t             dout
);
    import gcs_pkg::*;

    cord_t                dout_reg;
    cord_t                dout_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [AW-1:0] at;

    // One rotation step: turn towards zero residual angle
    always_comb
    begin
        xs = din.x >>> step;
        ys = din.y >>> step;
        at = gcs_atan(step);
        dout_next = din;
        if (din.z >= 0)
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - at;
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

FILE: rtl/gcs_vec_cell.sv
`timescale 1ns / 1ps
module gcs_vec_cell (
    input  logic                       clk,
    input  logic [gcs_pkg::STEP_W-1:0] step,
    input  gcs_pkg::cord_t             din,
    output gcs_pkg::cord_t             dout
);
    import gcs_pkg::*;

    cord_t                dout_reg;
    cord_t                dout_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [AW-1:0] at;

    // One vectoring step: drive y towards zero, accumulate the angle
    always_comb
    begin
        xs = din.x >>> step;
        ys = din.y >>> step;
        at = gcs_atan(step);
        dout_next = din;
        if (din.y > 0)
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + at;
        end
        else
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - at;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

FILE: rtl/gcs_sqrt_cell.sv
`timescale 1ns / 1ps
module gcs_sqrt_cell (
    input  logic                       clk,
    input  logic [gcs_pkg::STEP_W-1:0] step,
    input  gcs_pkg::sq_t               din,
    output gcs_pkg::sq_t               dout
);
    import gcs_pkg::*;

    sq_t             dout_reg;
    sq_t             dout_next;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W:0]   trial;

    // One root digit: trial subtract of (root + 4^step)
    always_comb
    begin
        bitv  = SQ_W'(1) << {step, 1'b0};
        trial = {1'b0, din.r} + {1'b0, bitv};
        if ({1'b0, din.v} >= trial)
        begin
            dout_next.v = din.v - trial[SQ_W-1:0];
            dout_next.r = (din.r >> 1) + bitv;
        end
        else
        begin
            dout_next.v = din.v;
            dout_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

FILE: rtl/gcs_div_cell.sv
`timescale 1ns / 1ps
module gcs_div_cell (
    input  logic                       clk,
    input  logic [gcs_pkg::DIV_IW-1:0] bit_idx,
    input  logic [gcs_pkg::HOUR_W-1:0] divisor,
    input  gcs_pkg::div_t              din,
    output gcs_pkg::div_t              dout
);
    import gcs_pkg::*;

    div_t            dout_reg;
    div_t            dout_next;
    logic [HOUR_W:0] t;

    // One restoring quotient bit
    always_comb
    begin
        t = {din.rem, din.n[bit_idx]};
        dout_next = din;
        if (t >= {1'b0, divisor})
        begin
            dout_next.rem = HOUR_W'(t - {1'b0, divisor});
            dout_next.q[bit_idx] = 1'b1;
        end
        else
        begin
            dout_next.rem = t[HOUR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

FILE: rtl/great_circle_speed_and_heading_core.sv
`timescale 1ns / 1ps
// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+----------------------
// request   | in        | point_count, first_/second_lat/lon/hour   | start high, busy low
// result    | out       | motion_valid, speed_knots, compass_point  | done, one cycle
// register  | in/out    | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// One request is taken every cycle; busy never rises. Each result passes
// through the entry register, rotation row, product and root operand registers,
// square root row, vectoring row, divider row and result register in that order.
// Reset (rst_n low) clears the in-flight valid bits and loads the radius
// register with 3959 miles. The receiver cannot stall; results are strobed.
module great_circle_speed_and_heading_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         point_count,
    input  logic signed [19:0] first_lat,
    input  logic signed [20:0] first_lon,
    input  logic [9:0]         first_hour,
    input  logic signed [19:0] second_lat,
    input  logic signed [20:0] second_lon,
    input  logic [9:0]         second_hour,
    output logic               done,
    output logic               motion_valid,
    output logic [13:0]        speed_knots,
    output logic [3:0]         compass_point,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gcs_pkg::*;

    // ---------------------------------------------------------------
    // Register port: radius and its product with nm-per-degree
    // ---------------------------------------------------------------
    logic [RAD_W-1:0] radius_reg;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIUS);
    assign k_next = K_W'(pwdata[RAD_W-1:0]) * K_W'(NM_PER_DEG_Q24);
    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(RADIUS_RESET);
            k_reg      <= K_W'(K_RESET);
        end
        else if (wr_en)
        begin
            radius_reg <= pwdata[RAD_W-1:0];
            k_reg      <= k_next;
        end
    end

    // ---------------------------------------------------------------
    // Side line: valid, motion flag and hour difference per request
    // ---------------------------------------------------------------
    side_t side_reg [0:ST_OUT-1];
    side_t side_next;

    assign side_next.vld   = start && !busy;
    assign side_next.ok    = (point_count >= 4'd2) && (first_hour == '0)
                             && (second_hour != '0);
    assign side_next.hours = second_hour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ST_OUT; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < ST_OUT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Entry: form the five angles, wrap and fold, seed the rotations
    // lane 0 lat1, lane 1 lat2, lane 2 half dlat, lane 3 half dlon,
    // lane 4 dlon
    // ---------------------------------------------------------------
    logic signed [RW-1:0] dlat;
    logic signed [RW-1:0] dlon;
    cord_t                s0_next [0:NLANE-1];
    cord_t                s0_reg  [0:NLANE-1];

    always_comb
    begin
        dlat = RW'(second_lat) - RW'(first_lat);
        dlon = RW'(second_lon) - RW'(first_lon);
        s0_next[0] = gcs_rot_init(RW'(first_lat) <<< 4);
        s0_next[1] = gcs_rot_init(RW'(second_lat) <<< 4);
        s0_next[2] = gcs_rot_init(dlat <<< 3);
        s0_next[3] = gcs_rot_init(dlon <<< 3);
        s0_next[4] = gcs_rot_init(dlon <<< 4);
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            s0_reg[l] <= s0_next[l];
        end
    end

    // ---------------------------------------------------------------
    // Rotation row: five lanes, one cell per CORDIC step
    // ---------------------------------------------------------------
    cord_t rot_w [0:CORDIC_STEPS][0:NLANE-1];

    genvar gj, gl;
    generate
        for (gl = 0; gl < NLANE; gl++)
        begin : g_rot_seed
            assign rot_w[0][gl] = s0_reg[gl];
        end
        for (gj = 0; gj < CORDIC_STEPS; gj++)
        begin : g_rot
            for (gl = 0; gl < NLANE; gl++)
            begin : g_lane
                gcs_rot_cell u_cell (
                    .clk  (clk),
                    .step (STEP_W'(gj)),
                    .din  (rot_w[gj][gl]),
                    .dout (rot_w[gj+1][gl])
                );
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Products: clamp sines and cosines, form the Q16 products
    // ---------------------------------------------------------------
    logic signed [TW-1:0] p_sd_reg, p_cc_reg, p_sn_reg;
    logic signed [TW-1:0] p_by_reg, p_t1_reg, p_t2_reg, p_cn_reg;
    logic signed [TW-1:0] s1, c1, s2, c2, sdh, snh, sn, cn;

    always_comb
    begin
        s1  = gcs_sin(rot_w[CORDIC_STEPS][0]);
        c1  = gcs_cos(rot_w[CORDIC_STEPS][0]);
        s2  = gcs_sin(rot_w[CORDIC_STEPS][1]);
        c2  = gcs_cos(rot_w[CORDIC_STEPS][1]);
        sdh = gcs_sin(rot_w[CORDIC_STEPS][2]);
        snh = gcs_sin(rot_w[CORDIC_STEPS][3]);
        sn  = gcs_sin(rot_w[CORDIC_STEPS][4]);
        cn  = gcs_cos(rot_w[CORDIC_STEPS][4]);
    end

    always_ff @(posedge clk)
    begin
        p_sd_reg <= gcs_mulq(sdh, sdh);
        p_cc_reg <= gcs_mulq(c1, c2);
        p_sn_reg <= gcs_mulq(snh, snh);
        p_by_reg <= gcs_mulq(sn, c2);
        p_t1_reg <= gcs_mulq(c1, s2);
        p_t2_reg <= gcs_mulq(s1, c2);
        p_cn_reg <= cn;
    end

    // ---------------------------------------------------------------
    // Haversine term and bearing vector
    // ---------------------------------------------------------------
    logic signed [TW:0]   h_sum;
    logic [HW-1:0]        h_next, h_reg;
    logic signed [TW:0]   bx_next, bx_reg;
    logic signed [TW-1:0] by_reg;

    always_comb
    begin
        h_sum   = (TW+1)'(p_sd_reg) + (TW+1)'(gcs_mulq(p_cc_reg, p_sn_reg));
        bx_next = (TW+1)'(p_t1_reg) - (TW+1)'(gcs_mulq(p_t2_reg, p_cn_reg));
        if (h_sum < 0)
            h_next = '0;
        else if (h_sum > (TW+1)'(ONE_Q16))
            h_next = HW'(ONE_Q16);
        else
            h_next = HW'(h_sum);
    end

    always_ff @(posedge clk)
    begin
        h_reg  <= h_next;
        bx_reg <= bx_next;
        by_reg <= p_by_reg;
    end

    // ---------------------------------------------------------------
    // Root operands; bring the bearing vector to the right half plane
    // ---------------------------------------------------------------
    sq_t                  sqx_next, sqy_next, sqx_reg, sqy_reg;
    cord_t                bear_next;
    logic signed [XW-1:0] bx_w, by_w;
    logic                 b_off;

    always_comb
    begin
        sqx_next.v = {HW'(ONE_Q16) - h_reg, 16'b0};
        sqx_next.r = '0;
        sqy_next.v = {h_reg, 16'b0};
        sqy_next.r = '0;
        b_off = bx_reg[TW];
        bx_w  = XW'(bx_reg);
        by_w  = XW'(by_reg);
        bear_next.x   = b_off ? -bx_w : bx_w;
        bear_next.y   = b_off ? -by_w : by_w;
        bear_next.z   = '0;
        bear_next.tag = {b_off, (by_reg == '0)};
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
    end

    // ---------------------------------------------------------------
    // Square root row, two lanes; hold the bearing vector alongside,
    // one stage for the operand register plus one per root cell
    // ---------------------------------------------------------------
    sq_t   sqx_w [0:SQ_N];
    sq_t   sqy_w [0:SQ_N];
    cord_t bline_reg [0:SQ_N];

    assign sqx_w[0] = sqx_reg;
    assign sqy_w[0] = sqy_reg;

    generate
        for (gj = 0; gj < SQ_N; gj++)
        begin : g_sqrt
            gcs_sqrt_cell u_x (
                .clk  (clk),
                .step (STEP_W'(SQ_N - 1 - gj)),
                .din  (sqx_w[gj]),
                .dout (sqx_w[gj+1])
            );
            gcs_sqrt_cell u_y (
                .clk  (clk),
                .step (STEP_W'(SQ_N - 1 - gj)),
                .din  (sqy_w[gj]),
                .dout (sqy_w[gj+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        bline_reg[0] <= bear_next;
        for (int k = 1; k <= SQ_N; k++)
        begin
            bline_reg[k] <= bline_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Vectoring rows: central angle and bearing; a zero y skips to 0
    // ---------------------------------------------------------------
    cord_t vd_w [0:CORDIC_STEPS];
    cord_t vb_w [0:CORDIC_STEPS];

    always_comb
    begin
        vd_w[0].x   = XW'(sqx_w[SQ_N].r[HW-1:0]);
        vd_w[0].y   = XW'(sqy_w[SQ_N].r[HW-1:0]);
        vd_w[0].z   = '0;
        vd_w[0].tag = {1'b0, (sqy_w[SQ_N].r == '0)};
    end

    assign vb_w[0] = bline_reg[SQ_N];

    generate
        for (gj = 0; gj < CORDIC_STEPS; gj++)
        begin : g_vec
            gcs_vec_cell u_d (
                .clk  (clk),
                .step (STEP_W'(gj)),
                .din  (vd_w[gj]),
                .dout (vd_w[gj+1])
            );
            gcs_vec_cell u_b (
                .clk  (clk),
                .step (STEP_W'(gj)),
                .din  (vb_w[gj]),
                .dout (vb_w[gj+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Distance numerator and bearing in [0, 360)
    // ---------------------------------------------------------------
    logic signed [AW-1:0] zd, zb;
    logic [ZC_W-1:0]      zc;
    logic [ZC_W:0]        a2;
    logic [NUM_W-1:0]     num_next, num_reg;
    logic signed [RW-1:0] ab;
    logic [B_W-1:0]       b_next, b_reg;

    always_comb
    begin
        zd = vd_w[CORDIC_STEPS].z;
        if (vd_w[CORDIC_STEPS].tag[0] || (zd < 0))
            zc = '0;
        else if (zd > AW'(ANG_QUARTER))
            zc = ZC_W'(ANG_QUARTER);
        else
            zc = ZC_W'(zd);
        a2 = {zc, 1'b0};
        num_next = k_reg * a2;

        zb = vb_w[CORDIC_STEPS].tag[0] ? '0 : vb_w[CORDIC_STEPS].z;
        ab = RW'(zb) + (vb_w[CORDIC_STEPS].tag[1] ? RW'(ANG_HALF) : RW'(0));
        if (ab < 0)
            ab = ab + RW'(ANG_FULL);
        else if (ab >= RW'(ANG_FULL))
            ab = ab - RW'(ANG_FULL);
        b_next = B_W'(ab);
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        b_reg   <= b_next;
    end

    // ---------------------------------------------------------------
    // Round by half the hour scale, drop 40 bits; sector index by 22.5
    // ---------------------------------------------------------------
    logic [NUM_W:0]      nsum;
    logic [DIVN_W-1:0]   n2_next, n2_reg;
    logic [B_W:0]        bsec;
    logic [9:0]          bv;
    logic [20:0]         bprod;
    logic [CP_W-1:0]     idx_next, idx_reg;

    always_comb
    begin
        nsum     = (NUM_W+1)'(num_reg) + ((NUM_W+1)'(side_reg[ST_Q1].hours) << 39);
        n2_next  = DIVN_W'(nsum >> 40);
        bsec     = (B_W+1)'(b_reg) + (B_W+1)'(COMPASS_OFFSET);
        bv       = 10'(bsec >> 15);
        bprod    = bv * 21'(RECIP_45_Q16);
        idx_next = CP_W'(bprod >> 16);
    end

    always_ff @(posedge clk)
    begin
        n2_reg  <= n2_next;
        idx_reg <= idx_next;
    end

    // ---------------------------------------------------------------
    // Divider row: one quotient bit per cell; hold the index alongside
    // ---------------------------------------------------------------
    div_t          dv_w [0:DIV_N];
    logic [CP_W-1:0] cline_reg [0:DIV_N-1];

    always_comb
    begin
        dv_w[0].n   = n2_reg;
        dv_w[0].rem = '0;
        dv_w[0].q   = '0;
    end

    generate
        for (gj = 0; gj < DIV_N; gj++)
        begin : g_div
            gcs_div_cell u_cell (
                .clk     (clk),
                .bit_idx (DIV_IW'(DIVN_W - 1 - gj)),
                .divisor (side_reg[ST_DV0 + gj - 1].hours),
                .din     (dv_w[gj]),
                .dout    (dv_w[gj+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        cline_reg[0] <= idx_reg;
        for (int k = 1; k < DIV_N; k++)
        begin
            cline_reg[k] <= cline_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Result register: saturate speed, zero speed and compass point when no motion
    // ---------------------------------------------------------------
    logic              done_reg;
    logic              mv_reg;
    logic [SPD_W-1:0]  spd_reg;
    logic [CP_W-1:0]   cp_reg;
    logic [SPD_W-1:0]  spd_next;
    side_t             side_last;

    assign side_last = side_reg[ST_OUT-1];

    always_comb
    begin
        if (!side_last.ok)
            spd_next = '0;
        else if (dv_w[DIV_N].q > DIVN_W'(SPEED_MAX))
            spd_next = SPD_W'(SPEED_MAX);
        else
            spd_next = SPD_W'(dv_w[DIV_N].q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_last.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg  <= side_last.ok;
        spd_reg <= spd_next;
        cp_reg  <= side_last.ok ? cline_reg[DIV_N-1] : '0;
    end

    assign done          = done_reg;
    assign motion_valid  = mv_reg;
    assign speed_knots   = spd_reg;
    assign compass_point = cp_reg;
endmodule
